// ===== rtl/id3fw_pkg.sv =====
// id3fw_pkg: shared types, constants and frame id decode for the id3v2 frame walker
// used by id3fw_step and id3v2_frame_walker; no dependencies
package id3fw_pkg;

  localparam int unsigned TAG_W     = 28;
  localparam int unsigned CONSUME_W = 30;
  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned ID_KEEP_W = 24;

  localparam logic [CONSUME_W-1:0] HEADER_BYTES = CONSUME_W'(10);

  localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
  localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
  localparam logic [31:0] ID_TALB = 32'h5441_4c42;
  localparam logic [31:0] ID_TYER = 32'h5459_4552;
  localparam logic [31:0] ID_APIC = 32'h4150_4943;

  typedef enum logic [2:0] {
    PH_ID      = 3'd0,
    PH_SIZE    = 3'd1,
    PH_FLAGS   = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_STOPPED = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_OTHER   = 3'd0,
    KIND_TITLE   = 3'd1,
    KIND_ARTIST  = 3'd2,
    KIND_ALBUM   = 3'd3,
    KIND_YEAR    = 3'd4,
    KIND_PICTURE = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_RUNNING = 2'd0,
    CAUSE_TAG_END = 2'd1,
    CAUSE_PADDING = 2'd2,
    CAUSE_BAD_SIZE = 2'd3
  } cause_t;

  typedef struct packed {
    phase_t                 phase;
    logic [1:0]             field_count;
    logic [ID_KEEP_W-1:0]   id_shift;
    logic [SIZE_W-1:0]      size_shift;
    logic [TAG_W-1:0]       payload_left;
    logic [CONSUME_W-1:0]   consumed;
    kind_t                  kind;
    logic                   first_payload;
    cause_t                 cause;
  } walk_state_t;

  typedef struct packed {
    logic [7:0]       text_byte;
    logic             text_valid;
    kind_t            frame_kind;
    logic [TAG_W-1:0] frame_length;
    logic             frame_begin;
    logic             frame_finish;
    logic             stopped;
    cause_t           stop_cause;
  } result_t;

  localparam walk_state_t WALK_RESET = '{
    phase:         PH_ID,
    field_count:   2'd0,
    id_shift:      '0,
    size_shift:    '0,
    payload_left:  '0,
    consumed:      '0,
    kind:          KIND_OTHER,
    first_payload: 1'b1,
    cause:         CAUSE_RUNNING
  };

  function automatic kind_t classify(input logic [31:0] id);
    kind_t k;
    k = KIND_OTHER;
    if (id == ID_TIT2) k = KIND_TITLE;
    else if (id == ID_TPE1) k = KIND_ARTIST;
    else if (id == ID_TALB) k = KIND_ALBUM;
    else if (id == ID_TYER) k = KIND_YEAR;
    else if (id == ID_APIC) k = KIND_PICTURE;
    return k;
  endfunction

  function automatic logic is_text(input kind_t k);
    return (k == KIND_TITLE) || (k == KIND_ARTIST) || (k == KIND_ALBUM) || (k == KIND_YEAR);
  endfunction

endpackage

// ===== rtl/id3v2_frame_walker.sv =====
// id3v2_frame_walker: top level, walk state register, result register and handshakes
// depends on id3fw_pkg and id3fw_step
//
// usage:
//   s_tdata carries one raw byte of the tag body per word. each accepted byte
//   yields exactly one result word on the m_ side.
//   cfg_valid/cfg_data write tag_length (cfg_ready is always high); a write
//   restarts the walk and must only happen while no result is pending.
//   the result of an accepted byte is registered and valid on the m_ side in the next cycle.
//   throughput: one byte per cycle unless stalled; the walk state updates at
//   the accept edge and the result register frees itself whenever m_tready is high.
//   stall: while m_tready is low and a result is held, s_tready drops and the
//   held result stays stable.
//   reset: tag_length returns to 0, the walk restarts at a frame id and the
//   result register empties. with tag_length 0 the first byte ends the walk.
//   once stopped, bytes are still taken and each gives a result with only
//   stopped and stop_cause set, until tag_length is written again.
module id3v2_frame_walker import id3fw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [27:0] cfg_data,      // tag_length
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,       // text_byte, frame_length, frame_begin, stopped, stop_cause
  output logic [3:0]  m_tuser,       // text_valid, frame_kind
  output logic        m_tlast        // frame_finish
);

  logic [TAG_W-1:0] tag_length;
  walk_state_t      st;
  walk_state_t      st_next;
  result_t          step_res;
  result_t          res;
  logic             s_accept;
  logic             cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign s_tready  = !m_tvalid || m_tready;
  assign s_accept  = s_tvalid && s_tready;

  id3fw_step u_step (
    .cur        (st),
    .tag_length (tag_length),
    .data_byte  (s_tdata),
    .nxt        (st_next),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_length <= '0;
      st         <= WALK_RESET;
    end else if (cfg_write) begin
      tag_length <= cfg_data;
      st         <= WALK_RESET;
    end else if (s_accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      res <= step_res;
    end
  end

  assign m_tdata = {res.stop_cause, res.stopped, res.frame_begin, res.frame_length, res.text_byte};
  assign m_tuser = {res.frame_kind, res.text_valid};
  assign m_tlast = res.frame_finish;

`ifndef SYNTHESIS
  a_cause_matches_stop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.stopped == (res.stop_cause != CAUSE_RUNNING)))
    else $error("stop cause disagrees with stopped flag");

  a_text_only_in_text_frame: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.text_valid) |-> (is_text(res.frame_kind) && !res.frame_begin))
    else $error("text byte outside a text frame payload");

  a_begin_not_finish: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.frame_begin && res.frame_finish))
    else $error("frame begin and finish on the same word");

  a_stop_is_sticky: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_STOPPED && !cfg_write) |=> (st.phase == PH_STOPPED))
    else $error("walk left stopped state without a restart");
`endif

endmodule

// ===== rtl/id3fw_step.sv =====
// id3fw_step: next walk state and result for one tag byte
// depends on id3fw_pkg
module id3fw_step import id3fw_pkg::*; (
  input  walk_state_t      cur,
  input  logic [TAG_W-1:0] tag_length,
  input  logic [7:0]       data_byte,
  output walk_state_t      nxt,
  output result_t          res
);

  logic [31:0]          id_word;
  logic [TAG_W-1:0]     left_dec;
  logic [TAG_W-1:0]     flen;

  assign id_word  = {cur.id_shift, data_byte};
  assign flen     = cur.size_shift[TAG_W-1:0];
  assign left_dec = (cur.payload_left != '0) ? cur.payload_left - 1'b1 : cur.payload_left;

  always_comb begin
    nxt = cur;
    res = '0;
    case (cur.phase)
      PH_ID: begin
        if (cur.field_count == 2'd0 && cur.consumed >= CONSUME_W'(tag_length)) begin
          nxt.phase = PH_STOPPED;
          nxt.cause = CAUSE_TAG_END;
        end else if (cur.field_count == 2'd0 && data_byte == 8'd0) begin
          nxt.phase = PH_STOPPED;
          nxt.cause = CAUSE_PADDING;
        end else begin
          nxt.id_shift = id_word[ID_KEEP_W-1:0];
          if (cur.field_count == 2'd3) begin
            nxt.kind        = classify(id_word);
            nxt.field_count = 2'd0;
            nxt.size_shift  = '0;
            nxt.phase       = PH_SIZE;
          end else begin
            nxt.field_count = cur.field_count + 2'd1;
          end
        end
      end
      PH_SIZE: begin
        nxt.size_shift = {cur.size_shift[SIZE_W-9:0], data_byte};
        if (cur.field_count == 2'd3) begin
          nxt.field_count = 2'd0;
          nxt.phase       = PH_FLAGS;
        end else begin
          nxt.field_count = cur.field_count + 2'd1;
        end
      end
      PH_FLAGS: begin
        if (cur.field_count == 2'd0) begin
          nxt.field_count = 2'd1;
        end else begin
          nxt.field_count = 2'd0;
          if (cur.size_shift == '0 || cur.size_shift > SIZE_W'(tag_length)) begin
            nxt.phase = PH_STOPPED;
            nxt.cause = CAUSE_BAD_SIZE;
          end else begin
            nxt.consumed      = cur.consumed + HEADER_BYTES;
            nxt.payload_left  = flen;
            nxt.first_payload = 1'b1;
            nxt.phase         = PH_PAYLOAD;
            res.frame_begin   = 1'b1;
            res.frame_kind    = cur.kind;
            res.frame_length  = flen;
          end
        end
      end
      PH_PAYLOAD: begin
        res.frame_kind   = cur.kind;
        res.frame_length = flen;
        if (!cur.first_payload && is_text(cur.kind)) begin
          res.text_valid = 1'b1;
          res.text_byte  = data_byte;
        end
        nxt.first_payload = 1'b0;
        nxt.payload_left  = left_dec;
        if (left_dec == '0) begin
          res.frame_finish = 1'b1;
          nxt.consumed     = cur.consumed + CONSUME_W'(flen);
          nxt.id_shift     = '0;
          nxt.field_count  = 2'd0;
          nxt.phase        = PH_ID;
        end
      end
      default: begin
        nxt.phase = PH_STOPPED;
      end
    endcase
    res.stopped    = (nxt.phase == PH_STOPPED);
    res.stop_cause = (nxt.phase == PH_STOPPED) ? nxt.cause : CAUSE_RUNNING;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for id3v2_frame_walker, streams tag bodies byte by byte
// and checks every result word against an in-bench frame walk tracker; depends on id3fw_pkg
module tb_top;
  import id3fw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ITEM_TARGET = 1600;
  localparam logic [27:0] TAG_MAX = 28'hFFF_FFFF;

  class walk_scoreboard;
    logic [27:0] tag_len;
    phase_t ph;
    logic [1:0] cnt;
    logic [31:0] id_acc;
    logic [31:0] size_acc;
    logic [27:0] left;
    logic [29:0] consumed;
    kind_t kind;
    logic first;
    cause_t cause;
    result_t predicted_words[$];
    int mismatches;
    int sent_bytes;

    function new();
      mismatches = 0;
      sent_bytes = 0;
      restart('0);
    endfunction

    function void restart(logic [27:0] len);
      tag_len = len;
      ph = PH_ID;
      cnt = '0;
      id_acc = '0;
      size_acc = '0;
      left = '0;
      consumed = '0;
      kind = KIND_OTHER;
      first = 1'b1;
      cause = CAUSE_RUNNING;
    endfunction

    function kind_t kind_of_id(logic [31:0] id);
      case (id)
        ID_TIT2: return KIND_TITLE;
        ID_TPE1: return KIND_ARTIST;
        ID_TALB: return KIND_ALBUM;
        ID_TYER: return KIND_YEAR;
        ID_APIC: return KIND_PICTURE;
        default: return KIND_OTHER;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      result_t w;
      w = '0;
      sent_bytes++;
      case (ph)
        PH_ID: begin
          if (cnt == 2'd0 && consumed >= tag_len) begin
            ph = PH_STOPPED;
            cause = CAUSE_TAG_END;
          end else if (cnt == 2'd0 && b == 8'h00) begin
            ph = PH_STOPPED;
            cause = CAUSE_PADDING;
          end else begin
            id_acc = {id_acc[23:0], b};
            if (cnt == 2'd3) begin
              kind = kind_of_id(id_acc);
              cnt = '0;
              size_acc = '0;
              ph = PH_SIZE;
            end else begin
              cnt = cnt + 2'd1;
            end
          end
        end
        PH_SIZE: begin
          size_acc = {size_acc[23:0], b};
          if (cnt == 2'd3) begin
            cnt = '0;
            ph = PH_FLAGS;
          end else begin
            cnt = cnt + 2'd1;
          end
        end
        PH_FLAGS: begin
          if (cnt == 2'd0) begin
            cnt = 2'd1;
          end else begin
            cnt = '0;
            if (size_acc == 32'd0 || size_acc > tag_len) begin
              ph = PH_STOPPED;
              cause = CAUSE_BAD_SIZE;
            end else begin
              consumed = consumed + HEADER_BYTES;
              left = size_acc[27:0];
              first = 1'b1;
              ph = PH_PAYLOAD;
              w.frame_begin = 1'b1;
              w.frame_kind = kind;
              w.frame_length = size_acc[27:0];
            end
          end
        end
        PH_PAYLOAD: begin
          w.frame_kind = kind;
          w.frame_length = size_acc[27:0];
          if (!first && (kind == KIND_TITLE || kind == KIND_ARTIST ||
                         kind == KIND_ALBUM || kind == KIND_YEAR)) begin
            w.text_valid = 1'b1;
            w.text_byte = b;
          end
          first = 1'b0;
          if (left != '0) left = left - 28'd1;
          if (left == '0) begin
            w.frame_finish = 1'b1;
            consumed = consumed + 30'(size_acc[27:0]);
            id_acc = '0;
            cnt = '0;
            ph = PH_ID;
          end
        end
        default: ph = PH_STOPPED;
      endcase
      w.stopped = (ph == PH_STOPPED);
      w.stop_cause = (ph == PH_STOPPED) ? cause : CAUSE_RUNNING;
      predicted_words.push_back(w);
    endfunction

    function string show(result_t r);
      return $sformatf("text %h/%b kind %0d len %0d begin %b finish %b stopped %b cause %0d",
                       r.text_byte, r.text_valid, r.frame_kind, r.frame_length,
                       r.frame_begin, r.frame_finish, r.stopped, r.stop_cause);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (predicted_words.size() == 0) begin
        if (mismatches < 10) $display("mismatch: unexpected word, got %s", show(got));
        mismatches++;
        return;
      end
      exp = predicted_words.pop_front();
      if (got.text_byte !== exp.text_byte || got.text_valid !== exp.text_valid ||
          got.frame_kind !== exp.frame_kind || got.frame_length !== exp.frame_length ||
          got.frame_begin !== exp.frame_begin || got.frame_finish !== exp.frame_finish ||
          got.stopped !== exp.stopped || got.stop_cause !== exp.stop_cause) begin
        if (mismatches < 10) begin
          $display("mismatch: expected %s", show(exp));
          $display("          got      %s", show(got));
        end
        mismatches++;
      end
    endfunction

    function int pending();
      return predicted_words.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [27:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // text_byte, frame_length, frame_begin, stopped, stop_cause
  logic [3:0]  m_tuser;   // text_valid, frame_kind
  logic        m_tlast;   // frame_finish

  id3v2_frame_walker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  walk_scoreboard sb = new();
  logic [7:0] tag_bytes[$];
  bit quiet_src;
  bit quiet_sink;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(quiet_src);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic send_tag();
    foreach (tag_bytes[i]) push_byte(tag_bytes[i]);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    tag_bytes.delete();
  endtask

  task automatic write_tag_length(input logic [27:0] len);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    sb.restart(len);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic append_frame(input logic [31:0] id, input logic [31:0] size,
                              input bit with_payload);
    for (int i = 3; i >= 0; i--) tag_bytes.push_back(id[8*i +: 8]);
    for (int i = 3; i >= 0; i--) tag_bytes.push_back(size[8*i +: 8]);
    tag_bytes.push_back(8'($urandom_range(0, 255)));
    tag_bytes.push_back(8'($urandom_range(0, 255)));
    if (with_payload)
      for (int i = 0; i < size; i++) tag_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // receive side, one word per handshake
  initial begin
    result_t got;
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait(quiet_sink);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.text_byte = m_tdata[7:0];
      got.frame_length = m_tdata[35:8];
      got.frame_begin = m_tdata[36];
      got.stopped = m_tdata[37];
      got.stop_cause = cause_t'(m_tdata[39:38]);
      got.text_valid = m_tuser[0];
      got.frame_kind = kind_t'(m_tuser[3:1]);
      got.frame_finish = m_tlast;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  initial begin
    logic [31:0] known_ids[5];
    logic [31:0] id;
    logic [31:0] size;
    logic [27:0] len;
    int total;
    int nframes;
    bit bad;
    known_ids = '{ID_TIT2, ID_TPE1, ID_TALB, ID_TYER, ID_APIC};
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    quiet_src = 1'b0;
    quiet_sink = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // tag length is zero out of reset, so the first byte ends the walk
    tag_bytes.push_back(8'h54);
    send_tag();

    // title with an embedded zero and a full byte, then padding
    write_tag_length(TAG_MAX);
    append_frame(ID_TIT2, 32'd3, 1'b0);
    tag_bytes.push_back(8'h00);
    tag_bytes.push_back(8'h00);
    tag_bytes.push_back(8'hFF);
    tag_bytes.push_back(8'h00);
    send_tag();

    // picture frame with zero size
    write_tag_length(28'd16);
    append_frame(ID_APIC, 32'd0, 1'b0);
    send_tag();

    while (sb.sent_bytes < ITEM_TARGET) begin
      quiet_src = ($urandom_range(0, 3) == 0);
      quiet_sink = ($urandom_range(0, 3) == 0);
      total = 0;
      bad = 1'b0;
      nframes = $urandom_range(1, 6);
      for (int f = 0; f < nframes && !bad; f++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: id = known_ids[$urandom_range(0, 4)];
          5: id = known_ids[$urandom_range(0, 4)] ^ (32'h1 << $urandom_range(0, 23));
          default: id = {8'($urandom_range(1, 255)), 24'($urandom)};
        endcase
        case ($urandom_range(0, 19))
          0: size = 32'd0;
          1: size = {4'($urandom_range(1, 15)), 28'($urandom)};
          2: size = 32'd1;
          default: size = 32'($urandom_range(1, 12));
        endcase
        bad = (size == 32'd0 || size > {4'h0, TAG_MAX});
        append_frame(id, size, !bad);
        if (!bad) total += 10 + int'(size);
      end
      case ($urandom_range(0, 3))
        0: len = 28'(total);
        1: begin
          len = 28'(total + $urandom_range(1, 40));
          repeat ($urandom_range(1, 4)) tag_bytes.push_back(8'h00);
        end
        2: len = 28'($urandom_range(0, total));
        default: begin
          case ($urandom_range(0, 2))
            0: len = '0;
            1: len = TAG_MAX;
            default: len = 28'($urandom);
          endcase
        end
      endcase
      repeat ($urandom_range(0, 3)) tag_bytes.push_back(8'($urandom_range(0, 255)));
      write_tag_length(len);
      send_tag();
    end

    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/id3fw_pkg.sv
rtl/id3fw_step.sv
rtl/id3v2_frame_walker.sv
tb/sv/tb_top.sv
